// ===== rtl/euclidean_distance_engine_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Euclidean distance engine.
// Each macro expands to one labeled concurrent assertion with a reset guard.
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_DISTANCE_ENGINE_CORE_ASSERT_SVH
`define EUCLIDEAN_DISTANCE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication.
`define EDE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("euclidean distance engine assertion failed");

// Next-cycle implication.
`define EDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("euclidean distance engine assertion failed");

`endif

// ===== rtl/ede_pkg.sv =====
// ----------------------------------------------------------------------------
// ede_pkg
// Shared constants, types and state codes of the Euclidean distance engine.
// ----------------------------------------------------------------------------
package ede_pkg;

   localparam int LANES             = 4;
   localparam int ELEM_BITS         = 16;
   localparam int MAX_VECTOR_LENGTH = 4096;
   localparam int SQ_BITS           = 2 * ELEM_BITS;
   localparam int TREE_BITS         = SQ_BITS + 2;
   localparam int SUM_BITS          = 44;
   localparam int ACC_BITS          = SUM_BITS + 1;
   localparam int DIST_BITS         = SUM_BITS / 2;
   localparam int REM_BITS          = DIST_BITS + 1;
   localparam int CNT_BITS          = $clog2(DIST_BITS);

   // Largest sum a vector of the allowed length can reach.
   localparam logic [63:0] ELEM_MAX_MAG = 64'((2 ** ELEM_BITS) - 1);
   localparam logic [SUM_BITS-1:0] SUM_BOUND =
      SUM_BITS'(64'(MAX_VECTOR_LENGTH) * ELEM_MAX_MAG * ELEM_MAX_MAG);

   typedef logic signed [ELEM_BITS-1:0] elem_type;
   typedef logic [SQ_BITS-1:0]          square_type;

   typedef struct packed {
      logic                valid;
      logic [SUM_BITS-1:0] sum;
      logic                sat;
   } handoff_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]  squared_distance;
      logic [DIST_BITS-1:0] distance;
      logic                 saturated;
   } result_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_RUN,
      SQ_DONE
   } sqrt_state_type;

endpackage

// ===== rtl/ede_channels.sv =====
// ----------------------------------------------------------------------------
// ede channel interfaces
// Valid/ready channels for the request words and the result words.
// ----------------------------------------------------------------------------
interface ede_req_if;
   logic               valid;
   logic               ready;
   ede_pkg::elem_type  query_lane_0;
   ede_pkg::elem_type  query_lane_1;
   ede_pkg::elem_type  query_lane_2;
   ede_pkg::elem_type  query_lane_3;
   ede_pkg::elem_type  data_lane_0;
   ede_pkg::elem_type  data_lane_1;
   ede_pkg::elem_type  data_lane_2;
   ede_pkg::elem_type  data_lane_3;
   logic               last_group;

   modport source (
      output valid, query_lane_0, query_lane_1, query_lane_2, query_lane_3,
             data_lane_0, data_lane_1, data_lane_2, data_lane_3, last_group,
      input  ready
   );
   modport sink (
      input  valid, query_lane_0, query_lane_1, query_lane_2, query_lane_3,
             data_lane_0, data_lane_1, data_lane_2, data_lane_3, last_group,
      output ready
   );
endinterface

interface ede_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ede_pkg::SUM_BITS-1:0]   squared_distance;
   logic [ede_pkg::DIST_BITS-1:0]  distance;
   logic                           saturated;

   modport source (
      output valid, squared_distance, distance, saturated,
      input  ready
   );
   modport sink (
      input  valid, squared_distance, distance, saturated,
      output ready
   );
endinterface

// ===== rtl/euclidean_distance_engine_core.sv =====
// ----------------------------------------------------------------------------
// euclidean_distance_engine_core
// A last request word passes the lane registers and the tree register, and its sum then
// loads the square root unit. Throughput: one request word per cycle, except that a last
// word waits in the tree stage, freezing the pipe, until the 22-step square root of the
// previous vector is done and its result taken.
// Reset (synchronous, active high) empties the pipe and clears the accumulator.
// ----------------------------------------------------------------------------
module euclidean_distance_engine_core (
   input  logic       clock,
   input  logic       reset,
   ede_req_if.sink    req_ch,
   ede_rsp_if.source  rsp_ch
);

   // Each request word carries four query and four data elements. Four lanes
   // form the squared differences in parallel and register them. The merge
   // stage adds the four squares in a registered tree and then adds the group
   // total into a running sum, clamped at the largest sum a vector of the
   // maximum length can reach. When the last word of a vector reaches the
   // accumulator, the clamped sum and the overflow flag move to the square
   // root unit and the accumulator clears, so the next vector streams in
   // while the root is being worked out.

   ede_pkg::elem_type     query_elems [ede_pkg::LANES];
   ede_pkg::elem_type     data_elems  [ede_pkg::LANES];
   ede_pkg::square_type   squares     [ede_pkg::LANES];
   logic                  advance;
   logic                  sqrt_busy;
   ede_pkg::handoff_type  handoff;
   ede_pkg::result_type   result;
   logic                  rsp_valid;

   assign query_elems[0] = req_ch.query_lane_0;
   assign query_elems[1] = req_ch.query_lane_1;
   assign query_elems[2] = req_ch.query_lane_2;
   assign query_elems[3] = req_ch.query_lane_3;
   assign data_elems[0]  = req_ch.data_lane_0;
   assign data_elems[1]  = req_ch.data_lane_1;
   assign data_elems[2]  = req_ch.data_lane_2;
   assign data_elems[3]  = req_ch.data_lane_3;

   // The pipe moves whenever it is not holding a last word for a busy root unit.
   assign req_ch.ready = advance;

   for (genvar i = 0; i < ede_pkg::LANES; i++) begin : g_lane
      ede_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .query   (query_elems[i]),
         .data    (data_elems[i]),
         .square  (squares[i])
      );
   end

   ede_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last_group),
      .squares   (squares),
      .sqrt_busy (sqrt_busy),
      .advance   (advance),
      .handoff   (handoff)
   );

   // The root unit's registers double as the output register of the block.
   ede_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .handoff   (handoff),
      .busy      (sqrt_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .result    (result)
   );

   assign rsp_ch.valid            = rsp_valid;
   assign rsp_ch.squared_distance = result.squared_distance;
   assign rsp_ch.distance         = result.distance;
   assign rsp_ch.saturated        = result.saturated;

endmodule

// ===== rtl/ede_lane.sv =====
// ----------------------------------------------------------------------------
// ede_lane
// One lane: squared difference of a query and a data element, registered.
// ----------------------------------------------------------------------------
module ede_lane (
   input  logic                clock,
   input  logic                advance,
   input  ede_pkg::elem_type   query,
   input  ede_pkg::elem_type   data,
   output ede_pkg::square_type square
);

   logic signed [ede_pkg::ELEM_BITS:0] diff;
   logic [ede_pkg::ELEM_BITS:0]        mag;
   ede_pkg::square_type                square_in;
   ede_pkg::square_type                square_ff;

   always_comb begin
      diff      = {query[ede_pkg::ELEM_BITS-1], query} - {data[ede_pkg::ELEM_BITS-1], data};
      mag       = diff[ede_pkg::ELEM_BITS] ? -diff : diff;
      // The magnitude never exceeds 2^ELEM_BITS - 1, so its top bit is dropped.
      square_in = ede_pkg::SQ_BITS'(mag[ede_pkg::ELEM_BITS-1:0])
                * ede_pkg::SQ_BITS'(mag[ede_pkg::ELEM_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         square_ff <= square_in;
      end
   end

   assign square = square_ff;

endmodule

// ===== rtl/ede_merge.sv =====
// ----------------------------------------------------------------------------
// ede_merge
// Adds the lane squares in a registered tree and accumulates with a clamp.
// ----------------------------------------------------------------------------
module ede_merge (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   input  ede_pkg::square_type    squares [ede_pkg::LANES],
   input  logic                   sqrt_busy,
   output logic                   advance,
   output ede_pkg::handoff_type   handoff
);

   logic                            lane_valid_ff, lane_valid_in;
   logic                            lane_last_ff;
   logic                            tree_valid_ff, tree_valid_in;
   logic                            tree_last_ff;
   logic [ede_pkg::TREE_BITS-1:0]   tree_sum_ff, tree_sum_in;
   logic [ede_pkg::SUM_BITS-1:0]    acc_ff, acc_in;
   logic                            ovf_ff, ovf_in;
   logic [ede_pkg::ACC_BITS-1:0]    acc_sum;
   logic                            over;
   logic [ede_pkg::SUM_BITS-1:0]    clamped;

   // The whole pipe freezes only while a last word waits for the root unit.
   assign advance = !(tree_valid_ff && tree_last_ff && sqrt_busy);

   always_comb begin
      lane_valid_in = req_valid;
      tree_valid_in = lane_valid_ff;
      tree_sum_in   = ede_pkg::TREE_BITS'(squares[0]) + ede_pkg::TREE_BITS'(squares[1])
                    + ede_pkg::TREE_BITS'(squares[2]) + ede_pkg::TREE_BITS'(squares[3]);

      acc_sum = ede_pkg::ACC_BITS'(acc_ff) + ede_pkg::ACC_BITS'(tree_sum_ff);
      over    = acc_sum > ede_pkg::ACC_BITS'(ede_pkg::SUM_BOUND);
      clamped = over ? ede_pkg::SUM_BOUND : acc_sum[ede_pkg::SUM_BITS-1:0];

      acc_in = acc_ff;
      ovf_in = ovf_ff;
      handoff.valid = 1'b0;
      handoff.sum   = clamped;
      handoff.sat   = ovf_ff || over;
      if (advance && tree_valid_ff) begin
         if (tree_last_ff) begin
            handoff.valid = 1'b1;
            acc_in        = '0;
            ovf_in        = 1'b0;
         end else begin
            acc_in = clamped;
            ovf_in = ovf_ff || over;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
         tree_valid_ff <= 1'b0;
         acc_ff        <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         if (advance) begin
            lane_valid_ff <= lane_valid_in;
            tree_valid_ff <= tree_valid_in;
         end
         acc_ff <= acc_in;
         ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_last_ff <= req_last;
         tree_last_ff <= lane_last_ff;
         tree_sum_ff  <= tree_sum_in;
      end
   end

endmodule

// ===== rtl/ede_sqrt.sv =====
// ----------------------------------------------------------------------------
// ede_sqrt
// Restoring integer square root, one root bit per cycle, with result register.
// ----------------------------------------------------------------------------
module ede_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  ede_pkg::handoff_type  handoff,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ede_pkg::result_type   result
);

   ede_pkg::sqrt_state_type          state_ff, state_in;
   logic [ede_pkg::CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [ede_pkg::SUM_BITS-1:0]     rad_ff, rad_in;
   logic [ede_pkg::SUM_BITS-1:0]     sqd_ff;
   logic [ede_pkg::DIST_BITS-1:0]    root_ff, root_in;
   logic [ede_pkg::REM_BITS-1:0]     rem_ff, rem_in;
   logic                             sat_ff;
   logic                             step_en;
   logic                             last_step;
   logic [ede_pkg::REM_BITS+1:0]     rem_shift;
   logic [ede_pkg::REM_BITS+1:0]     trial;
   logic                             fits;

   assign last_step = cnt_ff == ede_pkg::CNT_BITS'(ede_pkg::DIST_BITS - 1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ede_pkg::SQ_IDLE: begin
            if (handoff.valid) begin
               state_in = ede_pkg::SQ_RUN;
            end
         end
         ede_pkg::SQ_RUN: begin
            if (last_step) begin
               state_in = ede_pkg::SQ_DONE;
            end
         end
         ede_pkg::SQ_DONE: begin
            if (rsp_ready) begin
               state_in = ede_pkg::SQ_IDLE;
            end
         end
         default: begin
            state_in = ede_pkg::SQ_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      busy      = state_ff != ede_pkg::SQ_IDLE;
      rsp_valid = state_ff == ede_pkg::SQ_DONE;
      step_en   = state_ff == ede_pkg::SQ_RUN;
   end

   // One step brings down the next two radicand bits and tries 4*root + 1.
   always_comb begin
      rem_shift = {rem_ff, rad_ff[ede_pkg::SUM_BITS-1 -: 2]};
      trial     = {1'b0, root_ff, 2'b01};
      fits      = rem_shift >= trial;
      rad_in    = {rad_ff[ede_pkg::SUM_BITS-3:0], 2'b00};
      root_in   = {root_ff[ede_pkg::DIST_BITS-2:0], fits};
      rem_in    = fits ? ede_pkg::REM_BITS'(rem_shift - trial)
                       : rem_shift[ede_pkg::REM_BITS-1:0];
      cnt_in    = cnt_ff + ede_pkg::CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ede_pkg::SQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (handoff.valid && !busy) begin
         rad_ff  <= handoff.sum;
         sqd_ff  <= handoff.sum;
         sat_ff  <= handoff.sat;
         root_ff <= '0;
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end else if (step_en) begin
         rad_ff  <= rad_in;
         root_ff <= root_in;
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign result.squared_distance = sqd_ff;
   assign result.distance         = root_ff;
   assign result.saturated        = sat_ff;

endmodule

// ===== rtl/ede_checker.sv =====
// ----------------------------------------------------------------------------
// ede_checker
// Port-level checks on the result words of the distance engine.
// ----------------------------------------------------------------------------
`include "euclidean_distance_engine_core_assert.svh"

module ede_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ede_pkg::SUM_BITS-1:0]   squared_distance,
   input logic [ede_pkg::DIST_BITS-1:0]  distance,
   input logic                           saturated
);

   logic [ede_pkg::ACC_BITS-1:0] root_sq;
   logic [ede_pkg::ACC_BITS-1:0] next_sq;
   logic [ede_pkg::ACC_BITS-1:0] sqd_wide;
   logic [ede_pkg::SUM_BITS+ede_pkg::DIST_BITS:0] rsp_word;
   logic                         root_ok;
   logic                         at_bound;

   assign root_sq  = ede_pkg::ACC_BITS'(distance) * ede_pkg::ACC_BITS'(distance);
   assign next_sq  = (ede_pkg::ACC_BITS'(distance) + ede_pkg::ACC_BITS'(1))
                   * (ede_pkg::ACC_BITS'(distance) + ede_pkg::ACC_BITS'(1));
   assign sqd_wide = ede_pkg::ACC_BITS'(squared_distance);
   assign rsp_word = {squared_distance, distance, saturated};
   assign root_ok  = root_sq <= sqd_wide && next_sq > sqd_wide;
   assign at_bound = squared_distance == ede_pkg::SUM_BOUND;

   // A stalled result word keeps its contents.
   `EDE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // The sum never passes the clamp bound.
   `EDE_ASSERT_SAME(a_sum_bound, clock, reset, rsp_valid, squared_distance <= ede_pkg::SUM_BOUND)

   // The distance is the floor of the square root of the squared distance.
   `EDE_ASSERT_SAME(a_root_floor, clock, reset, rsp_valid, root_ok)

   // A clamped vector reports exactly the bound.
   `EDE_ASSERT_SAME(a_sat_bound, clock, reset, rsp_valid && saturated, at_bound)

endmodule

bind euclidean_distance_engine_core ede_checker u_ede_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .squared_distance (rsp_ch.squared_distance),
   .distance         (rsp_ch.distance),
   .saturated        (rsp_ch.saturated)
);

// ===== verif/euclidean_distance_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// euclidean_distance_engine_core_tb
// Self-checking bench for the L2 distance engine. Request words are streamed
// as vectors of element groups with random spacing, and a scoreboard predicts
// the squared distance, its floor root and the clamp flag for every last word.
// ----------------------------------------------------------------------------
package euclidean_distance_tb_pkg;

   import ede_pkg::*;

   // Largest magnitude a lane difference can reach, and the clamp point of the sum.
   localparam logic [63:0] PEAK_DIFF = (64'd1 << ELEM_BITS) - 64'd1;
   localparam logic [63:0] SUM_LIMIT = 64'(MAX_VECTOR_LENGTH) * PEAK_DIFF * PEAK_DIFF;

   typedef struct packed {
      elem_type [LANES-1:0] query;
      elem_type [LANES-1:0] data;
      logic                 last;
   } group_word_type;

   class distance_scoreboard;

      logic [63:0]  running_total;
      bit           clamped;
      result_type   expected_distances[$];
      int unsigned  mismatches;

      function new();
         running_total = '0;
         clamped = 1'b0;
         mismatches = 0;
      endfunction

      // Bit-by-bit floor square root.
      function logic [63:0] floor_root(logic [63:0] value);
         logic [63:0] root;
         logic [63:0] trial;
         root = '0;
         for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= value) begin
               root = trial;
            end
         end
         return root;
      endfunction

      function void note_group(group_word_type w);
         logic [63:0] lane_square [LANES];
         logic [63:0] left_pair;
         logic [63:0] right_pair;
         logic [63:0] group_total;
         longint      diff;
         result_type  predicted;
         for (int i = 0; i < LANES; i++) begin
            diff = longint'($signed(w.query[i])) - longint'($signed(w.data[i]));
            if (diff < 0) begin
               diff = -diff;
            end
            lane_square[i] = 64'(diff) * 64'(diff);
         end
         left_pair = lane_square[0] + lane_square[1];
         right_pair = lane_square[2] + lane_square[3];
         if (left_pair > SUM_LIMIT || right_pair > SUM_LIMIT ||
             left_pair + right_pair > SUM_LIMIT) begin
            group_total = SUM_LIMIT;
            clamped = 1'b1;
         end else begin
            group_total = left_pair + right_pair;
         end
         if (running_total > SUM_LIMIT || group_total > SUM_LIMIT - running_total) begin
            running_total = SUM_LIMIT;
            clamped = 1'b1;
         end else begin
            running_total += group_total;
         end
         if (w.last) begin
            predicted.squared_distance = running_total[SUM_BITS-1:0];
            predicted.distance = DIST_BITS'(floor_root(running_total));
            predicted.saturated = clamped;
            expected_distances.push_back(predicted);
            running_total = '0;
            clamped = 1'b0;
         end
      endfunction

      function void check_distance(result_type seen);
         result_type want;
         if (expected_distances.size() == 0) begin
            $error("result word with none pending: squared_distance %0d",
                   seen.squared_distance);
            mismatches++;
            return;
         end
         want = expected_distances.pop_front();
         if (seen.squared_distance !== want.squared_distance) begin
            $error("squared_distance: expected %0d, actual %0d",
                   want.squared_distance, seen.squared_distance);
            mismatches++;
         end
         if (seen.distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, seen.distance);
            mismatches++;
         end
         if (seen.saturated !== want.saturated) begin
            $error("saturated: expected %0d, actual %0d", want.saturated, seen.saturated);
            mismatches++;
         end
      endfunction

   endclass

endpackage

module euclidean_distance_engine_core_tb;

   import ede_pkg::*;
   import euclidean_distance_tb_pkg::*;

   localparam elem_type ELEM_TOP    = 16'sh7fff;
   localparam elem_type ELEM_BOTTOM = 16'sh8000;

   // The engine clamps only after this many groups of peak difference.
   localparam int GROUPS_TO_LIMIT = MAX_VECTOR_LENGTH / LANES;

   logic clock;
   logic reset;

   // When set, neither side inserts idle cycles, so back-to-back words are seen.
   bit quiet;

   distance_scoreboard scoreboard = new();

   ede_req_if req_bus ();
   ede_rsp_if rsp_bus ();

   euclidean_distance_engine_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 40);
   endfunction

   // Element values lean toward the extremes and small numbers, where the
   // arithmetic has its corners, but the full range is still covered.
   function automatic elem_type random_elem();
      case ($urandom_range(0, 5))
         0, 1: return elem_type'($urandom);
         2: begin
            case ($urandom_range(0, 3))
               0: return ELEM_TOP;
               1: return ELEM_BOTTOM;
               2: return elem_type'(-1);
               default: return elem_type'(0);
            endcase
         end
         3, 4: return elem_type'(int'($urandom_range(0, 200)) - 100);
         default: return ELEM_TOP - elem_type'($urandom_range(0, 15));
      endcase
   endfunction

   function automatic group_word_type random_group(bit last);
      group_word_type w;
      for (int i = 0; i < LANES; i++) begin
         w.query[i] = random_elem();
         // Equal elements give a zero difference on that lane.
         w.data[i] = ($urandom_range(0, 9) == 0) ? w.query[i] : random_elem();
      end
      w.last = last;
      return w;
   endfunction

   function automatic group_word_type uniform_group(elem_type q, elem_type d, bit last);
      group_word_type w;
      for (int i = 0; i < LANES; i++) begin
         w.query[i] = q;
         w.data[i] = d;
      end
      w.last = last;
      return w;
   endfunction

   // Drives one request word at the falling edge and holds it until the engine
   // takes it. Valid stays high across back-to-back words, and the task returns
   // at the falling edge that follows acceptance.
   task automatic send_group(input group_word_type w);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.query_lane_0 = w.query[0];
      req_bus.query_lane_1 = w.query[1];
      req_bus.query_lane_2 = w.query[2];
      req_bus.query_lane_3 = w.query[3];
      req_bus.data_lane_0  = w.data[0];
      req_bus.data_lane_1  = w.data[1];
      req_bus.data_lane_2  = w.data[2];
      req_bus.data_lane_3  = w.data[3];
      req_bus.last_group   = w.last;
      req_bus.valid        = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      scoreboard.note_group(w);
      @(negedge clock);
   endtask

   // Result side. Ready runs high for a while and then drops for a random
   // stall, so results find the receiver both willing and busy.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         rsp_bus.ready = 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         stall = quiet ? 0 : pick_gap();
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   // Every result word taken at a rising edge goes to the scoreboard.
   always @(posedge clock) begin
      result_type seen;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.squared_distance = rsp_bus.squared_distance;
         seen.distance = rsp_bus.distance;
         seen.saturated = rsp_bus.saturated;
         scoreboard.check_distance(seen);
      end
   end

   initial begin
      group_word_type w;
      int groups_sent;
      int vector_len;
      int roll;

      reset = 1'b1;
      quiet = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.query_lane_0 = '0;
      req_bus.query_lane_1 = '0;
      req_bus.query_lane_2 = '0;
      req_bus.query_lane_3 = '0;
      req_bus.data_lane_0 = '0;
      req_bus.data_lane_1 = '0;
      req_bus.data_lane_2 = '0;
      req_bus.data_lane_3 = '0;
      req_bus.last_group = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Single-group vectors straight out of reset: zero distance, the largest
      // difference in both directions, and equal extremes.
      send_group(uniform_group(elem_type'(0), elem_type'(0), 1'b1));
      send_group(uniform_group(ELEM_TOP, ELEM_BOTTOM, 1'b1));
      send_group(uniform_group(ELEM_BOTTOM, ELEM_TOP, 1'b1));
      send_group(uniform_group(ELEM_TOP, ELEM_TOP, 1'b1));
      send_group(uniform_group(ELEM_BOTTOM, ELEM_BOTTOM, 1'b1));

      // One lane at a time carries a large difference, so a crossed lane or a
      // wrong branch of the adder tree shows up.
      for (int i = 0; i < LANES; i++) begin
         w = uniform_group(elem_type'(0), elem_type'(0), 1'b1);
         w.query[i] = ELEM_TOP - elem_type'(i);
         w.data[i] = ELEM_BOTTOM + elem_type'(3 * i);
         send_group(w);
      end

      // Small sums, the first with a root that is not exact, so the floor is exercised.
      w = uniform_group(elem_type'(0), elem_type'(0), 1'b1);
      w.query[0] = elem_type'(1);
      w.query[1] = elem_type'(-1);
      send_group(w);
      send_group(uniform_group(elem_type'(2), elem_type'(-1), 1'b1));

      // Multi-group vectors that mix extremes and random content.
      send_group(uniform_group(ELEM_TOP, elem_type'(0), 1'b0));
      send_group(uniform_group(elem_type'(0), ELEM_BOTTOM, 1'b0));
      send_group(uniform_group(elem_type'(-1), elem_type'(1), 1'b1));
      send_group(random_group(1'b0));
      send_group(random_group(1'b1));

      // A vector of peak-difference groups that lands exactly on the clamp
      // point, then one small group that passes it and must raise the flag.
      for (int k = 0; k < GROUPS_TO_LIMIT; k++) begin
         send_group(uniform_group(ELEM_TOP, ELEM_BOTTOM, 1'b0));
      end
      send_group(uniform_group(elem_type'(1), elem_type'(0), 1'b1));

      // The flag and the sum must be clear again for the next vector.
      send_group(uniform_group(elem_type'(5), elem_type'(-7), 1'b1));

      // Random vectors, mostly short, some of moderate length. Now and then a
      // whole vector runs with no idling on either side.
      groups_sent = 0;
      while (groups_sent < 100) begin
         quiet = ($urandom_range(0, 7) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            vector_len = $urandom_range(1, 4);
         end else if (roll < 90) begin
            vector_len = $urandom_range(5, 16);
         end else begin
            vector_len = $urandom_range(17, 64);
         end
         for (int k = 0; k < vector_len; k++) begin
            send_group(random_group(k == vector_len - 1));
         end
         groups_sent += vector_len;
      end
      quiet = 1'b0;
      req_bus.valid = 1'b0;

      // Drain the outstanding results, then allow for the pipe latency in case
      // a stray word is still on its way.
      while (scoreboard.expected_distances.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (scoreboard.mismatches == 0) begin
         $display("euclidean_distance_engine_core verification clean");
      end else begin
         $display("euclidean_distance_engine_core verification failed");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #(12 * 1000000);
      $display("euclidean_distance_engine_core verification failed");
      $finish;
   end

endmodule
